@@ rtl/afc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// afc_pkg
// Shared constants for the aspect fit and crop rectangle calculator:
// register indexes, fill modes, aspect codes and the aspect ratio table.
// ----------------------------------------------------------------------------
package afc_pkg;

    // Default geometry
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // Configuration port widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ASPECT_CODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CROP_CODE   = 2'd2;

    // Fill modes
    localparam logic [1:0] FILL_STRETCH = 2'd0;
    localparam logic [1:0] FILL_FIT     = 2'd1;
    localparam logic [1:0] FILL_CROP    = 2'd2;

    // Aspect codes: first and last forced ratio
    localparam logic [3:0] ASPECT_16_9 = 4'd2;
    localparam logic [3:0] ASPECT_1_1  = 4'd11;

    // Reset values
    localparam logic [1:0] FILL_MODE_RST   = FILL_FIT;
    localparam logic [3:0] ASPECT_CODE_RST = ASPECT_16_9;
    localparam logic [3:0] CROP_CODE_RST   = 4'd0;

    // Ratio table, numerator over denominator, indexed by aspect code
    localparam int NUM_CODES = 12;
    localparam logic [63:0] RATIO_NUM [NUM_CODES] =
        '{64'd0, 64'd0, 64'd16, 64'd16, 64'd185, 64'd221,
          64'd235, 64'd239, 64'd4, 64'd5, 64'd5, 64'd1};
    localparam logic [63:0] RATIO_DEN [NUM_CODES] =
        '{64'd1, 64'd1, 64'd9, 64'd10, 64'd100, 64'd100,
          64'd100, 64'd100, 64'd3, 64'd4, 64'd3, 64'd1};

endpackage
`default_nettype wire

@@ rtl/afc_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// afc_div
// Pipelined radix-2 restoring divider, one quotient bit per stage.
// Quotient of ({rem0, dvd}) / dvs; rem0 must be below dvs.
// ----------------------------------------------------------------------------
module afc_div #(
    parameter int NW = 32,
    parameter int DW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [DW-1:0] i_rem0,
    input  wire logic [NW-1:0] i_dvd,
    input  wire logic [DW-1:0] i_dvs,
    output logic      [NW-1:0] o_quo
);

    logic [DW-1:0] r_rem [NW];
    logic [DW-1:0] n_rem [NW];
    logic [DW-1:0] r_dvs [NW];
    logic [DW-1:0] n_dvs [NW];
    logic [NW-1:0] r_dvd [NW];
    logic [NW-1:0] n_dvd [NW];
    logic [NW-1:0] r_quo [NW];
    logic [NW-1:0] n_quo [NW];

    logic [DW-1:0] a_rem [NW];
    logic [DW-1:0] a_dvs [NW];
    logic [NW-1:0] a_dvd [NW];
    logic [NW-1:0] a_quo [NW];

    // Stage inputs: ports for the first stage, previous stage otherwise
    always_comb begin
        a_rem[0] = i_rem0;
        a_dvs[0] = i_dvs;
        a_dvd[0] = i_dvd;
        a_quo[0] = '0;
        for (int k = 1; k < NW; k++) begin
            a_rem[k] = r_rem[k-1];
            a_dvs[k] = r_dvs[k-1];
            a_dvd[k] = r_dvd[k-1];
            a_quo[k] = r_quo[k-1];
        end
    end

    // One trial subtract per stage
    always_comb begin
        logic [DW:0] t;
        logic        qb;
        for (int k = 0; k < NW; k++) begin
            t  = {a_rem[k], a_dvd[k][NW-1]};
            qb = (t >= {1'b0, a_dvs[k]});
            if (qb) begin
                n_rem[k] = DW'(t - {1'b0, a_dvs[k]});
            end else begin
                n_rem[k] = t[DW-1:0];
            end
            n_dvs[k] = a_dvs[k];
            n_dvd[k] = a_dvd[k] << 1;
            n_quo[k] = {a_quo[k][NW-2:0], qb};
        end
    end

    // Advance all stages together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NW; k++) begin
                r_rem[k] <= n_rem[k];
                r_dvs[k] <= n_dvs[k];
                r_dvd[k] <= n_dvd[k];
                r_quo[k] <= n_quo[k];
            end
        end
    end

    assign o_quo = r_quo[NW-1];

endmodule
`default_nettype wire

@@ rtl/aspect_fit_crop_rect_calc_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aspect_fit_crop_rect_calc_top
// Destination and source rectangle calculator for aspect fit and crop.
// ----------------------------------------------------------------------------
// Takes one request per cycle unless stalled and returns one result per
// request, in order. Between them lie two radix-2 divider pipelines in
// series, each COORD_BITS+FRAC_BITS stages long: the first forms the frame
// and view aspects, the second the crop trims or the fitted height. When
// the result register is stalled the whole pipeline holds and i_valid is
// not taken.
// Configuration writes are always ready and must be made while idle.
module aspect_fit_crop_rect_calc_top #(
    parameter int COORD_BITS = afc_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = afc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // configuration
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [afc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [afc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // request
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [COORD_BITS-1:0]        i_frame_width,
    input  wire logic [COORD_BITS-1:0]        i_frame_height,
    input  wire logic [COORD_BITS-1:0]        i_view_width,
    input  wire logic [COORD_BITS-1:0]        i_view_height,
    // result
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic      [COORD_BITS-1:0]        o_dest_x,
    output logic      [COORD_BITS-1:0]        o_dest_y,
    output logic      [COORD_BITS-1:0]        o_dest_w,
    output logic      [COORD_BITS-1:0]        o_dest_h,
    output logic      [FRAC_BITS:0]           o_src_x,
    output logic      [FRAC_BITS:0]           o_src_y,
    output logic      [FRAC_BITS:0]           o_src_w,
    output logic      [FRAC_BITS:0]           o_src_h
);
    import afc_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int A  = F + 8;
    localparam int NW = C + F;

    localparam logic [A-1:0] ASP_MAX = '1;
    localparam logic [F:0]   ONE     = {1'b1, {F{1'b0}}};

    localparam logic [A-1:0] ASP_TAB [NUM_CODES] = '{
        A'((RATIO_NUM[0]  << F) / RATIO_DEN[0]),
        A'((RATIO_NUM[1]  << F) / RATIO_DEN[1]),
        A'((RATIO_NUM[2]  << F) / RATIO_DEN[2]),
        A'((RATIO_NUM[3]  << F) / RATIO_DEN[3]),
        A'((RATIO_NUM[4]  << F) / RATIO_DEN[4]),
        A'((RATIO_NUM[5]  << F) / RATIO_DEN[5]),
        A'((RATIO_NUM[6]  << F) / RATIO_DEN[6]),
        A'((RATIO_NUM[7]  << F) / RATIO_DEN[7]),
        A'((RATIO_NUM[8]  << F) / RATIO_DEN[8]),
        A'((RATIO_NUM[9]  << F) / RATIO_DEN[9]),
        A'((RATIO_NUM[10] << F) / RATIO_DEN[10]),
        A'((RATIO_NUM[11] << F) / RATIO_DEN[11])
    };

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0] r_fill_mode;
    logic [3:0] r_aspect_code;
    logic [3:0] r_crop_code;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_mode   <= FILL_MODE_RST;
            r_aspect_code <= ASPECT_CODE_RST;
            r_crop_code   <= CROP_CODE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FILL_MODE:   r_fill_mode   <= i_cfg_data[1:0];
                CFG_ASPECT_CODE: r_aspect_code <= i_cfg_data[3:0];
                CFG_CROP_CODE:   r_crop_code   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Global advance: hold everything while the result beat waits
    // ------------------------------------------------------------------
    logic en;
    logic r_o_valid;

    assign en      = !(r_o_valid && i_stall);
    assign o_stall = !en;

    // ------------------------------------------------------------------
    // First divider layer: frame aspect and view aspect
    // ------------------------------------------------------------------
    logic [NW-1:0] q_fa;
    logic [NW-1:0] q_ia;

    afc_div #(.NW(NW), .DW(C)) u_div_fa (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rem0 ({C{1'b0}}),
        .i_dvd  ({i_frame_width, {F{1'b0}}}),
        .i_dvs  (i_frame_height),
        .o_quo  (q_fa)
    );

    afc_div #(.NW(NW), .DW(C)) u_div_ia (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rem0 ({C{1'b0}}),
        .i_dvd  ({i_view_width, {F{1'b0}}}),
        .i_dvs  (i_view_height),
        .o_quo  (q_ia)
    );

    // Side line alongside the first layer
    logic         r_l1_valid [NW];
    logic         r_l1_act   [NW];
    logic [C-1:0] r_l1_vw    [NW];
    logic [C-1:0] r_l1_vh    [NW];
    logic         in_act;

    assign in_act = (r_fill_mode != FILL_STRETCH) && (i_frame_height != '0) &&
                    (i_view_height != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NW; k++) r_l1_valid[k] <= 1'b0;
        end else if (en) begin
            r_l1_valid[0] <= i_valid;
            for (int k = 1; k < NW; k++) r_l1_valid[k] <= r_l1_valid[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l1_act[0] <= in_act;
            r_l1_vw[0]  <= i_view_width;
            r_l1_vh[0]  <= i_view_height;
            for (int k = 1; k < NW; k++) begin
                r_l1_act[k] <= r_l1_act[k-1];
                r_l1_vw[k]  <= r_l1_vw[k-1];
                r_l1_vh[k]  <= r_l1_vh[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Middle stage: saturate aspects, apply forcing and crop code, compare
    // ------------------------------------------------------------------
    logic [A-1:0] fa_frame, ia_sat, fa_raw, ca, fa_eff;
    logic         forced, crop_act;

    always_comb begin
        fa_frame = (q_fa > NW'(ASP_MAX)) ? ASP_MAX : q_fa[A-1:0];
        ia_sat   = (q_ia > NW'(ASP_MAX)) ? ASP_MAX : q_ia[A-1:0];
        forced   = (r_aspect_code >= ASPECT_16_9) && (r_aspect_code <= ASPECT_1_1);
        crop_act = (r_crop_code >= ASPECT_16_9) && (r_crop_code <= ASPECT_1_1);
        fa_raw   = forced ? ASP_TAB[r_aspect_code] : fa_frame;
        ca       = crop_act ? ASP_TAB[r_crop_code] : fa_raw;
        fa_eff   = crop_act ? ca : fa_raw;
    end

    logic         r_m_valid;
    logic         r_m_act, r_m_crop_act, r_m_crop_gt, r_m_crop_lt, r_m_gt, r_m_lt;
    logic [C-1:0] r_m_vw, r_m_vh;
    logic [A-1:0] r_m_fa_raw, r_m_ca, r_m_fa, r_m_ia;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (en) begin
            r_m_valid <= r_l1_valid[NW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_act      <= r_l1_act[NW-1];
            r_m_vw       <= r_l1_vw[NW-1];
            r_m_vh       <= r_l1_vh[NW-1];
            r_m_crop_act <= crop_act;
            r_m_crop_gt  <= fa_raw > ca;
            r_m_crop_lt  <= fa_raw < ca;
            r_m_gt       <= fa_eff > ia_sat;
            r_m_lt       <= fa_eff < ia_sat;
            r_m_fa_raw   <= fa_raw;
            r_m_ca       <= ca;
            r_m_fa       <= fa_eff;
            r_m_ia       <= ia_sat;
        end
    end

    // ------------------------------------------------------------------
    // Second divider layer: crop code trim, and fit height or view trim
    // ------------------------------------------------------------------
    logic [A-1:0]    c_small, c_big, m_small, m_big, m_dvs;
    logic [A+NW-1:0] w_crop, w_main;

    always_comb begin
        c_small = r_m_crop_gt ? r_m_ca : r_m_fa_raw;
        c_big   = r_m_crop_gt ? r_m_fa_raw : r_m_ca;
        m_small = r_m_gt ? r_m_ia : r_m_fa;
        m_big   = r_m_gt ? r_m_fa : r_m_ia;
        w_crop  = (A+NW)'(c_small) << F;
        if (r_fill_mode == FILL_FIT) begin
            w_main = (A+NW)'(r_m_vw) << F;
            m_dvs  = r_m_fa;
        end else begin
            w_main = (A+NW)'(m_small) << F;
            m_dvs  = m_big;
        end
    end

    logic [NW-1:0] q_crop;
    logic [NW-1:0] q_main;

    afc_div #(.NW(NW), .DW(A)) u_div_crop (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rem0 (w_crop[A+NW-1:NW]),
        .i_dvd  (w_crop[NW-1:0]),
        .i_dvs  (c_big),
        .o_quo  (q_crop)
    );

    afc_div #(.NW(NW), .DW(A)) u_div_main (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rem0 (w_main[A+NW-1:NW]),
        .i_dvd  (w_main[NW-1:0]),
        .i_dvs  (m_dvs),
        .o_quo  (q_main)
    );

    // Side line alongside the second layer
    logic         r_l2_valid   [NW];
    logic         r_l2_act     [NW];
    logic         r_l2_crop_act[NW];
    logic         r_l2_crop_gt [NW];
    logic         r_l2_crop_lt [NW];
    logic         r_l2_gt      [NW];
    logic         r_l2_lt      [NW];
    logic [C-1:0] r_l2_vw      [NW];
    logic [C-1:0] r_l2_vh      [NW];
    logic [A-1:0] r_l2_fa      [NW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NW; k++) r_l2_valid[k] <= 1'b0;
        end else if (en) begin
            r_l2_valid[0] <= r_m_valid;
            for (int k = 1; k < NW; k++) r_l2_valid[k] <= r_l2_valid[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l2_act[0]      <= r_m_act;
            r_l2_crop_act[0] <= r_m_crop_act;
            r_l2_crop_gt[0]  <= r_m_crop_gt;
            r_l2_crop_lt[0]  <= r_m_crop_lt;
            r_l2_gt[0]       <= r_m_gt;
            r_l2_lt[0]       <= r_m_lt;
            r_l2_vw[0]       <= r_m_vw;
            r_l2_vh[0]       <= r_m_vh;
            r_l2_fa[0]       <= r_m_fa;
            for (int k = 1; k < NW; k++) begin
                r_l2_act[k]      <= r_l2_act[k-1];
                r_l2_crop_act[k] <= r_l2_crop_act[k-1];
                r_l2_crop_gt[k]  <= r_l2_crop_gt[k-1];
                r_l2_crop_lt[k]  <= r_l2_crop_lt[k-1];
                r_l2_gt[k]       <= r_l2_gt[k-1];
                r_l2_lt[k]       <= r_l2_lt[k-1];
                r_l2_vw[k]       <= r_l2_vw[k-1];
                r_l2_vh[k]       <= r_l2_vh[k-1];
                r_l2_fa[k]       <= r_l2_fa[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Assemble stage: trims, fitted width and height, rectangle select
    // ------------------------------------------------------------------
    logic [F:0]     r1, off1, ext1, r2, off2, ext2;
    logic [C+A-1:0] prod;
    logic [C-1:0]   n_dw, n_dh;
    logic [F:0]     n_sx, n_sy, n_sw, n_sh;

    always_comb begin
        r1   = (q_crop > NW'(ONE)) ? ONE : q_crop[F:0];
        off1 = (ONE - r1) >> 1;
        ext1 = ONE - {off1[F-1:0], 1'b0};
        r2   = (q_main > NW'(ONE)) ? ONE : q_main[F:0];
        off2 = (ONE - r2) >> 1;
        ext2 = ONE - {off2[F-1:0], 1'b0};
        prod = (C+A)'(r_l2_vh[NW-1]) * (C+A)'(r_l2_fa[NW-1]);

        n_dw = r_l2_vw[NW-1];
        n_dh = r_l2_vh[NW-1];
        n_sx = '0;
        n_sy = '0;
        n_sw = ONE;
        n_sh = ONE;
        if (r_l2_act[NW-1]) begin
            if (r_l2_crop_act[NW-1]) begin
                if (r_l2_crop_gt[NW-1]) begin
                    n_sx = off1;
                    n_sw = ext1;
                end else if (r_l2_crop_lt[NW-1]) begin
                    n_sy = off1;
                    n_sh = ext1;
                end
            end
            if (r_fill_mode == FILL_FIT) begin
                if (r_l2_gt[NW-1]) begin
                    n_dh = q_main[C-1:0];
                end else if (r_l2_lt[NW-1]) begin
                    n_dw = prod[F +: C];
                end
            end else if (r_fill_mode == FILL_CROP) begin
                if (r_l2_gt[NW-1]) begin
                    n_sx = off2;
                    n_sw = ext2;
                end else if (r_l2_lt[NW-1]) begin
                    n_sy = off2;
                    n_sh = ext2;
                end
            end
        end
    end

    logic         r_p_valid;
    logic [C-1:0] r_p_vw, r_p_vh, r_p_dw, r_p_dh;
    logic [F:0]   r_p_sx, r_p_sy, r_p_sw, r_p_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (en) begin
            r_p_valid <= r_l2_valid[NW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_vw <= r_l2_vw[NW-1];
            r_p_vh <= r_l2_vh[NW-1];
            r_p_dw <= n_dw;
            r_p_dh <= n_dh;
            r_p_sx <= n_sx;
            r_p_sy <= n_sy;
            r_p_sw <= n_sw;
            r_p_sh <= n_sh;
        end
    end

    // ------------------------------------------------------------------
    // Result register: center the destination
    // ------------------------------------------------------------------
    logic [C:0] diff_x, diff_y;

    assign diff_x = {1'b0, r_p_vw} - {1'b0, r_p_dw};
    assign diff_y = {1'b0, r_p_vh} - {1'b0, r_p_dh};

    logic [C-1:0] r_o_dx, r_o_dy, r_o_dw, r_o_dh;
    logic [F:0]   r_o_sx, r_o_sy, r_o_sw, r_o_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_dx <= diff_x[C:1];
            r_o_dy <= diff_y[C:1];
            r_o_dw <= r_p_dw;
            r_o_dh <= r_p_dh;
            r_o_sx <= r_p_sx;
            r_o_sy <= r_p_sy;
            r_o_sw <= r_p_sw;
            r_o_sh <= r_p_sh;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_dest_x = r_o_dx;
    assign o_dest_y = r_o_dy;
    assign o_dest_w = r_o_dw;
    assign o_dest_h = r_o_dh;
    assign o_src_x  = r_o_sx;
    assign o_src_y  = r_o_sy;
    assign o_src_w  = r_o_sw;
    assign o_src_h  = r_o_sh;

endmodule
`default_nettype wire

@@ rtl/afc_chk.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// afc_chk
// Port-level checks for the aspect fit and crop rectangle calculator.
// ----------------------------------------------------------------------------
module afc_chk #(
    parameter int COORD_BITS = afc_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = afc_pkg::FRAC_BITS_DEF
) (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_cfg_valid,
    input wire logic                           o_cfg_ready,
    input wire logic [afc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input wire logic [afc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input wire logic                           i_valid,
    input wire logic                           o_stall,
    input wire logic [COORD_BITS-1:0]          i_frame_width,
    input wire logic [COORD_BITS-1:0]          i_frame_height,
    input wire logic [COORD_BITS-1:0]          i_view_width,
    input wire logic [COORD_BITS-1:0]          i_view_height,
    input wire logic                           o_valid,
    input wire logic                           i_stall,
    input wire logic [COORD_BITS-1:0]          o_dest_x,
    input wire logic [COORD_BITS-1:0]          o_dest_y,
    input wire logic [COORD_BITS-1:0]          o_dest_w,
    input wire logic [COORD_BITS-1:0]          o_dest_h,
    input wire logic [FRAC_BITS:0]             o_src_x,
    input wire logic [FRAC_BITS:0]             o_src_y,
    input wire logic [FRAC_BITS:0]             o_src_w,
    input wire logic [FRAC_BITS:0]             o_src_h
);

    localparam logic [FRAC_BITS+1:0] ONE_X = {2'b01, {FRAC_BITS{1'b0}}};

    // Request side stalls exactly when the result beat is held
    a_stall_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> (o_stall == (o_valid && i_stall)))
        else $error("request stall does not follow held result");

    // A held result beat keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_dest_x) &&
            $stable(o_dest_w) && $stable(o_src_x) && $stable(o_src_w)))
        else $error("held result changed");

    // Horizontal source window is centered in the frame
    a_src_x_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (({1'b0, o_src_w} + {o_src_x, 1'b0}) == ONE_X))
        else $error("horizontal source window not centered");

    // Vertical source window is centered in the frame
    a_src_y_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (({1'b0, o_src_h} + {o_src_y, 1'b0}) == ONE_X))
        else $error("vertical source window not centered");

endmodule

bind aspect_fit_crop_rect_calc_top afc_chk #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
) u_afc_chk (.*);
`default_nettype wire
